// ===== sv/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared types, state encoding and constants of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int QueueDepth = 2;

	localparam logic [2:0] MaxBytes = 3'd4;
	localparam logic [2:0] LastDigestIdx = 3'd4;
	localparam logic [5:0] LenPos = 6'd56;
	localparam logic [6:0] BlockBytes = 7'd64;
	localparam logic [6:0] LastRound = 7'd79;
	localparam logic [7:0] MarkByte = 8'h80;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [4:0][31:0] HInit = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        last_word;
	} sha1_msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} sha1_dig_t;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        last;
	} sha1_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DATA,
		ST_MARK,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} sha1_state_t;

endpackage

// ===== sv/sha1_front.sv =====
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts message words, clamps the byte count and queues them for the core.
// ----------------------------------------------------------------------------
module sha1_front import sha1_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       msg_valid,
	output logic       msg_ready,
	input  sha1_msg_t  msg,
	output logic       item_valid,
	input  logic       item_ready,
	output sha1_item_t item
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	sha1_item_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	sha1_item_t cls;
	logic push;
	logic pop;

	always_comb begin
		cls.data = msg.data_word;
		cls.nbytes = (msg.valid_bytes > MaxBytes) ? MaxBytes : msg.valid_bytes;
		cls.last = msg.last_word;
	end

	assign msg_ready = (cnt_q != CW'(QUEUE_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item = mem_q[rd_q];
	assign push = msg_valid && msg_ready;
	assign pop = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

// ===== sv/sha1_back.sv =====
// ----------------------------------------------------------------------------
// SHA-1 core
// Packs bytes into the block buffer, pads, runs the 80 rounds and emits the
// digest words.
// ----------------------------------------------------------------------------
module sha1_back import sha1_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  sha1_item_t item,
	output logic       dig_valid,
	input  logic       dig_ready,
	output sha1_dig_t  dig
);

	sha1_state_t state_q;
	sha1_state_t state_d;
	sha1_state_t ret_q;
	sha1_state_t ret_d;
	sha1_state_t after;

	logic [511:0]      sched_q;
	logic [4:0][31:0]  work_q;
	logic [4:0][31:0]  chain_q;
	logic [63:0]       bit_len_q;
	logic [5:0]        pos_q;
	logic [6:0]        round_q;
	logic [2:0]        idx_q;
	logic [31:0]       data_q;
	logic [2:0]        nb_q;
	logic              last_q;

	logic [6:0]  room;
	logic [2:0]  put_n;
	logic [31:0] put_val;
	logic        fill;
	logic        take;
	logic        dig_done;
	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] tmp;
	logic [31:0] wx;
	logic [31:0] w_next;

	assign room = BlockBytes - {1'b0, pos_q};
	assign take = item_valid && item_ready;
	assign dig_done = dig_valid && dig_ready && (idx_q == LastDigestIdx);

	always_comb begin
		after = state_q;
		put_n = '0;
		put_val = '0;
		item_ready = 1'b0;
		dig_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item.nbytes != '0) begin
						after = ST_DATA;
					end else if (item.last) begin
						after = ST_MARK;
					end else begin
						after = ST_IDLE;
					end
				end
			end
			ST_DATA: begin
				put_n = ({4'b0, nb_q} > room) ? room[2:0] : nb_q;
				put_val = data_q;
				if (nb_q == put_n) begin
					after = last_q ? ST_MARK : ST_IDLE;
				end else begin
					after = ST_DATA;
				end
			end
			ST_MARK, ST_PAD: begin
				put_n = 3'd1;
				put_val = (state_q == ST_MARK) ? {MarkByte, 24'b0} : '0;
				after = (6'(pos_q + 6'd1) == LenPos) ? ST_LEN : ST_PAD;
			end
			ST_LEN: begin
				put_n = 3'd1;
				put_val = {bit_len_q[63:56], 24'b0};
				after = (&pos_q) ? ST_OUT : ST_LEN;
			end
			ST_ROUND: begin
				after = (round_q == LastRound) ? ST_FOLD : ST_ROUND;
			end
			ST_FOLD: begin
				after = ret_q;
			end
			ST_OUT: begin
				dig_valid = 1'b1;
				after = (dig_ready && (idx_q == LastDigestIdx)) ? ST_IDLE : ST_OUT;
			end
			default: begin
				after = ST_IDLE;
			end
		endcase
		fill = (put_n != '0) && (({1'b0, pos_q} + {4'b0, put_n}) == BlockBytes);
		ret_d = ret_q;
		if (fill) begin
			state_d = ST_ROUND;
			ret_d = after;
		end else begin
			state_d = after;
		end
	end

	always_comb begin
		if (round_q < 7'd20) begin
			f = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
			k = K0;
		end else if (round_q < 7'd40) begin
			f = work_q[1] ^ work_q[2] ^ work_q[3];
			k = K1;
		end else if (round_q < 7'd60) begin
			f = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) | (work_q[2] & work_q[3]);
			k = K2;
		end else begin
			f = work_q[1] ^ work_q[2] ^ work_q[3];
			k = K3;
		end
		tmp = {work_q[0][26:0], work_q[0][31:27]} + f + work_q[4] + sched_q[511:480] + k;
		wx = sched_q[95:64] ^ sched_q[255:224] ^ sched_q[447:416] ^ sched_q[511:480];
		w_next = {wx[30:0], wx[31]};
	end

	assign dig.digest_word = chain_q[idx_q];
	assign dig.word_index = idx_q;
	assign dig.digest_last = (idx_q == LastDigestIdx);

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= item.data;
			nb_q <= item.nbytes;
			last_q <= item.last;
		end
		if (put_n != '0) begin
			data_q <= data_q << {put_n, 3'b0};
			nb_q <= nb_q - put_n;
			case (put_n)
				3'd1: sched_q <= {sched_q[503:0], put_val[31:24]};
				3'd2: sched_q <= {sched_q[495:0], put_val[31:16]};
				3'd3: sched_q <= {sched_q[487:0], put_val[31:8]};
				3'd4: sched_q <= {sched_q[479:0], put_val};
				default: sched_q <= sched_q;
			endcase
		end
		if (fill) begin
			work_q <= chain_q;
		end
		if (state_q == ST_ROUND) begin
			sched_q <= {sched_q[479:0], w_next};
			work_q <= {work_q[3], work_q[2], {work_q[1][1:0], work_q[1][31:2]}, work_q[0], tmp};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= HInit;
			bit_len_q <= '0;
			pos_q <= '0;
			round_q <= '0;
			idx_q <= '0;
		end else begin
			if (put_n != '0) begin
				pos_q <= pos_q + {3'b0, put_n};
			end
			if (state_q == ST_DATA) begin
				bit_len_q <= bit_len_q + {58'b0, put_n, 3'b0};
			end else if (state_q == ST_LEN) begin
				bit_len_q <= {bit_len_q[55:0], 8'b0};
			end
			if (fill) begin
				round_q <= '0;
			end else if (state_q == ST_ROUND) begin
				round_q <= round_q + 7'd1;
			end
			if (state_q == ST_FOLD) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
			if (dig_valid && dig_ready) begin
				if (dig_done) begin
					idx_q <= '0;
					chain_q <= HInit;
					bit_len_q <= '0;
					pos_q <= '0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

endmodule

// ===== sv/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Hashes a byte stream given as big-endian words and returns the five digest
// words of each message.
// ----------------------------------------------------------------------------
// Message words enter through a short queue, so the source can keep writing
// while the core is busy. The core takes a word from the queue in its idle
// state and then packs its bytes in the data state; when the word straddles a
// block boundary, the block is compressed before the rest of the word is
// packed. Every 64-byte block is compressed in 80 rounds, and the result is
// then folded into the chaining words. A last word adds the 0x80 marker and
// zero padding up to byte 56, the eight length bytes, one more compression
// (two when the padding spills into an extra block) and five transactions
// on the digest channel.
module sha1_hash_engine import sha1_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_ready,
	input  sha1_msg_t msg,
	output logic      dig_valid,
	input  logic      dig_ready,
	output sha1_dig_t dig
);

	logic       item_valid;
	logic       item_ready;
	sha1_item_t item;

	sha1_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.msg(msg),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item)
	);

	sha1_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.dig_valid(dig_valid),
		.dig_ready(dig_ready),
		.dig(dig)
	);

endmodule
